@@ hdl/cdlg_pkg.sv @@
package cdlg_pkg;

	localparam int TableDepth = 8;
	localparam int IdxBits    = 3;
	localparam int FreqBits   = 22;
	localparam int PctBits    = 7;
	localparam int HoldBits   = 17;
	localparam int CntBits    = 4;
	localparam int AddrBits   = 5;

	localparam logic [FreqBits-1:0] FreqMax = {FreqBits{1'b1}};

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_DECIDE = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Register byte addresses.
	localparam logic [AddrBits-1:0] REG_LIMIT_MIN  = 5'd0;
	localparam logic [AddrBits-1:0] REG_LIMIT_MAX  = 5'd4;
	localparam logic [AddrBits-1:0] REG_DOWN_HOLD  = 5'd8;
	localparam logic [AddrBits-1:0] REG_GO_FAST    = 5'd12;
	localparam logic [AddrBits-1:0] REG_FAST_KHZ   = 5'd16;
	localparam logic [AddrBits-1:0] REG_BOOST_HOLD = 5'd20;
	localparam logic [AddrBits-1:0] REG_POINTS     = 5'd24;

	localparam logic [FreqBits-1:0] RST_MIN   = 22'd208000;
	localparam logic [FreqBits-1:0] RST_MAX   = 22'd1795000;
	localparam logic [FreqBits-1:0] RST_FAST  = 22'd1196000;
	localparam logic [PctBits-1:0]  RST_GOFAST = 7'd95;

	function automatic logic [FreqBits-1:0] init_khz(input logic [IdxBits-1:0] i);
		logic [FreqBits-1:0] r;
		case (i)
			3'd0: r = 22'd208000;
			3'd1: r = 22'd416000;
			3'd2: r = 22'd624000;
			3'd3: r = 22'd798000;
			3'd4: r = 22'd1196000;
			3'd5: r = 22'd1596000;
			3'd6: r = 22'd1795000;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [PctBits-1:0] init_up(input logic [IdxBits-1:0] i);
		logic [PctBits-1:0] r;
		case (i)
			3'd0: r = 7'd70;
			3'd1: r = 7'd75;
			3'd2: r = 7'd80;
			3'd3: r = 7'd85;
			3'd4: r = 7'd90;
			3'd5: r = 7'd95;
			3'd6: r = 7'd100;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [PctBits-1:0] init_down(input logic [IdxBits-1:0] i);
		logic [PctBits-1:0] r;
		case (i)
			3'd0: r = 7'd0;
			3'd1: r = 7'd45;
			3'd2: r = 7'd50;
			3'd3: r = 7'd55;
			3'd4: r = 7'd60;
			3'd5: r = 7'd65;
			3'd6: r = 7'd70;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Divider request and response between the sequencer and the divider.
	typedef struct packed {
		logic        start;
		logic [38:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [38:0] quo;
	} div_rsp_t;

endpackage

@@ hdl/cdlg_if.sv @@
interface cdlg_in_if;
	import cdlg_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [31:0]         wall_delta;
	logic [31:0]         idle_delta;
	logic [FreqBits-1:0] current_khz;
	logic                boost_request;
	logic [IdxBits-1:0]  point_index;
	logic [FreqBits-1:0] point_khz;
	logic [PctBits-1:0]  point_up;
	logic [PctBits-1:0]  point_down;

	modport source (output valid, cmd, wall_delta, idle_delta, current_khz, boost_request,
		point_index, point_khz, point_up, point_down, input ready);
	modport sink (input valid, cmd, wall_delta, idle_delta, current_khz, boost_request,
		point_index, point_khz, point_up, point_down, output ready);
endinterface

interface cdlg_out_if;
	import cdlg_pkg::*;
	logic                valid;
	logic                ready;
	logic                result_kind;
	logic [FreqBits-1:0] target_khz;
	logic                freq_changed;
	logic                write_ok;

	modport source (output valid, result_kind, target_khz, freq_changed, write_ok,
		input ready);
	modport sink (input valid, result_kind, target_khz, freq_changed, write_ok,
		output ready);
endinterface

@@ hdl/cdlg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module cdlg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cdlg_pkg::div_req_t req,
	output cdlg_pkg::div_rsp_t rsp
);
	import cdlg_pkg::*;

	logic [38:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] sub;

	// Shift in the next numerator bit and try to subtract.
	assign trial = {rem_q[31:0], quo_q[38]};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd39;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!sub[32]) begin
				rem_q <= sub;
				quo_q <= {quo_q[37:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[37:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

@@ hdl/cdlg_cfg.sv @@
// Configuration registers behind the APB-style port.
module cdlg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdlg_pkg::AddrBits-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [cdlg_pkg::FreqBits-1:0] limit_min_khz,
	output logic [cdlg_pkg::FreqBits-1:0] limit_max_khz,
	output logic [cdlg_pkg::HoldBits-1:0] down_hold_samples,
	output logic [cdlg_pkg::PctBits-1:0]  go_fast_load,
	output logic [cdlg_pkg::FreqBits-1:0] fast_khz,
	output logic [cdlg_pkg::HoldBits-1:0] boost_hold_samples,
	output logic [cdlg_pkg::CntBits-1:0]  points_in_use,
	output logic                          hold_wr
);
	import cdlg_pkg::*;

	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign hold_wr = wr && (paddr == REG_DOWN_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_min_khz      <= RST_MIN;
			limit_max_khz      <= RST_MAX;
			down_hold_samples  <= 17'd4;
			go_fast_load       <= RST_GOFAST;
			fast_khz           <= RST_FAST;
			boost_hold_samples <= 17'd1;
			points_in_use      <= 4'd7;
		end else if (wr) begin
			unique case (paddr)
				REG_LIMIT_MIN:  limit_min_khz      <= pwdata[FreqBits-1:0];
				REG_LIMIT_MAX:  limit_max_khz      <= pwdata[FreqBits-1:0];
				REG_DOWN_HOLD:  down_hold_samples  <= pwdata[HoldBits-1:0];
				REG_GO_FAST:    go_fast_load       <= pwdata[PctBits-1:0];
				REG_FAST_KHZ:   fast_khz           <= pwdata[FreqBits-1:0];
				REG_BOOST_HOLD: boost_hold_samples <= pwdata[HoldBits-1:0];
				REG_POINTS:     points_in_use      <= pwdata[CntBits-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (paddr)
			REG_LIMIT_MIN:  prdata = {10'd0, limit_min_khz};
			REG_LIMIT_MAX:  prdata = {10'd0, limit_max_khz};
			REG_DOWN_HOLD:  prdata = {15'd0, down_hold_samples};
			REG_GO_FAST:    prdata = {25'd0, go_fast_load};
			REG_FAST_KHZ:   prdata = {10'd0, fast_khz};
			REG_BOOST_HOLD: prdata = {15'd0, boost_hold_samples};
			REG_POINTS:     prdata = {28'd0, points_in_use};
			default:        prdata = '0;
		endcase
	end
endmodule

@@ hdl/cdlg_seq.sv @@
// Sequencer: walks the point table one entry a cycle and drives the divider.
module cdlg_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	cdlg_in_if.sink                       in_ch,
	cdlg_out_if.source                    out_ch,
	input  logic [cdlg_pkg::FreqBits-1:0] limit_min_khz,
	input  logic [cdlg_pkg::FreqBits-1:0] limit_max_khz,
	input  logic [cdlg_pkg::HoldBits-1:0] down_hold_samples,
	input  logic [cdlg_pkg::PctBits-1:0]  go_fast_load,
	input  logic [cdlg_pkg::FreqBits-1:0] fast_khz,
	input  logic [cdlg_pkg::HoldBits-1:0] boost_hold_samples,
	input  logic [cdlg_pkg::CntBits-1:0]  points_in_use,
	input  logic                          hold_wr,
	output cdlg_pkg::div_req_t            div_req,
	input  cdlg_pkg::div_rsp_t            div_rsp
);
	import cdlg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHOOSE, ST_LOADWAIT, ST_FIND, ST_JUDGE,
		ST_QWAIT, ST_PICK, ST_FINISH, ST_OUT
	} state_t;

	state_t state_q;

	logic [FreqBits-1:0] tab_khz_q  [TableDepth];
	logic [PctBits-1:0]  tab_up_q   [TableDepth];
	logic [PctBits-1:0]  tab_down_q [TableDepth];

	logic [HoldBits-1:0] hold_q;
	logic [PctBits-1:0]  peak_q;
	logic [FreqBits-1:0] cur_q;
	logic [IdxBits-1:0]  idx_q;
	logic [IdxBits-1:0]  pt_q;
	logic                raise_q;
	logic [FreqBits-1:0] tgt_q;
	logic                have_best_q, have_alt_q;
	logic [FreqBits-1:0] best_q, alt_q;
	logic [FreqBits-1:0] freq_q;

	logic                out_valid_q;
	logic                out_kind_q;
	logic [FreqBits-1:0] out_khz_q;
	logic                out_chg_q;
	logic                out_ok_q;

	logic [CntBits-1:0]  n_used;
	logic [IdxBits-1:0]  last_pt;
	logic [PctBits-1:0]  up_p, down_p;
	logic                do_raise, do_lower;
	logic [FreqBits-1:0] f_i;
	logic                in_lim;
	logic [38:0]         scaled_load;
	logic                wr_ok;
	logic [HoldBits-1:0] hold_dec;
	logic                accept;
	logic [FreqBits-1:0] pick_khz;

	// Points in use clamped to one through the table depth.
	always_comb begin
		if (points_in_use == '0)
			n_used = 4'd1;
		else if (points_in_use > CntBits'(TableDepth))
			n_used = CntBits'(TableDepth);
		else
			n_used = points_in_use;
	end
	assign last_pt = IdxBits'(n_used - 4'd1);

	// Peak vs threshold, cur nonzero; lowering also needs cur above limit_min.
	assign up_p     = tab_up_q[pt_q];
	assign down_p   = tab_down_q[pt_q];
	assign do_raise = (cur_q != '0) && (peak_q > up_p);
	assign do_lower = (cur_q != '0) && (peak_q < down_p) && (cur_q > limit_min_khz);
	assign scaled_load = 39'(peak_q) * 39'(cur_q);
	assign hold_dec  = (hold_q != '0) ? hold_q - 17'd1 : hold_q;

	assign f_i    = tab_khz_q[idx_q];
	assign in_lim = (f_i >= limit_min_khz) && (f_i <= limit_max_khz);

	// Result of the table walk, then the heavy-load rule on a raise.
	always_comb begin
		if (have_best_q)
			pick_khz = best_q;
		else if (have_alt_q)
			pick_khz = alt_q;
		else
			pick_khz = tgt_q;
		if (raise_q && (peak_q >= go_fast_load) && (fast_khz > pick_khz))
			pick_khz = fast_khz;
	end

	assign wr_ok  = in_ch.point_down <= in_ch.point_up;
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_kind  = out_kind_q;
	assign out_ch.target_khz   = out_khz_q;
	assign out_ch.freq_changed = out_chg_q;
	assign out_ch.write_ok     = out_ok_q;

	// Divider start pulses: load percent or target quotient.
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = 32'd1;
		if (state_q == ST_JUDGE && (do_raise || do_lower) && !(do_raise &&
			cur_q >= limit_max_khz)) begin
			div_req.start = 1'b1;
			div_req.num   = scaled_load;
			div_req.den   = do_raise ? 32'(up_p) : 32'(down_p);
		end
		if (state_q == ST_IDLE && accept && in_ch.cmd == CMD_SAMPLE &&
			in_ch.wall_delta != '0 && in_ch.wall_delta >= in_ch.idle_delta) begin
			div_req.start = 1'b1;
			div_req.num   = 39'(in_ch.wall_delta - in_ch.idle_delta) * 39'd100;
			div_req.den   = in_ch.wall_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_q      <= '0;
			peak_q      <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			pt_q        <= '0;
			raise_q     <= 1'b0;
			tgt_q       <= '0;
			have_best_q <= 1'b0;
			have_alt_q  <= 1'b0;
			best_q      <= '0;
			alt_q       <= '0;
			freq_q      <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_khz_q   <= '0;
			out_chg_q   <= 1'b0;
			out_ok_q    <= 1'b0;
			for (int i = 0; i < TableDepth; i++) begin
				tab_khz_q[i]  <= init_khz(IdxBits'(i));
				tab_up_q[i]   <= init_up(IdxBits'(i));
				tab_down_q[i] <= init_down(IdxBits'(i));
			end
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			if (hold_wr)
				hold_q <= 17'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q <= in_ch.current_khz;
						unique case (in_ch.cmd)
							CMD_SAMPLE: begin
								if (div_req.start)
									state_q <= ST_LOADWAIT;
							end
							CMD_DECIDE: begin
								if (in_ch.boost_request) begin
									hold_q    <= boost_hold_samples;
									peak_q    <= '0;
									freq_q    <= (in_ch.current_khz < fast_khz) ?
										fast_khz : in_ch.current_khz;
									state_q   <= ST_FINISH;
								end else begin
									idx_q   <= '0;
									state_q <= ST_FIND;
								end
							end
							CMD_WRITE: begin
								if (wr_ok) begin
									tab_khz_q[in_ch.point_index]  <= in_ch.point_khz;
									tab_up_q[in_ch.point_index]   <= in_ch.point_up;
									tab_down_q[in_ch.point_index] <= in_ch.point_down;
								end
								out_kind_q <= 1'b1;
								out_khz_q  <= '0;
								out_chg_q  <= 1'b0;
								out_ok_q   <= wr_ok;
								state_q    <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_LOADWAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.quo[PctBits-1:0] > peak_q)
							peak_q <= div_rsp.quo[PctBits-1:0];
						state_q <= ST_IDLE;
					end
				end
				// Locate the operating point for the present frequency.
				ST_FIND: begin
					if (idx_q >= last_pt || !(tab_khz_q[idx_q] < cur_q)) begin
						pt_q    <= (idx_q >= last_pt) ? last_pt : idx_q;
						state_q <= ST_JUDGE;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_JUDGE: begin
					freq_q  <= cur_q;
					raise_q <= do_raise;
					if (do_raise) begin
						hold_q <= down_hold_samples;
						if (cur_q < limit_max_khz)
							state_q <= ST_QWAIT;
						else
							state_q <= ST_FINISH;
					end else if (do_lower) begin
						hold_q <= hold_dec;
						state_q <= (hold_dec == '0) ? ST_QWAIT : ST_FINISH;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_QWAIT: begin
					if (div_rsp.done) begin
						if (raise_q && up_p == '0)
							tgt_q <= FreqMax;
						else if (div_rsp.quo > 39'(FreqMax))
							tgt_q <= FreqMax;
						else
							tgt_q <= div_rsp.quo[FreqBits-1:0];
						idx_q       <= '0;
						have_best_q <= 1'b0;
						have_alt_q  <= 1'b0;
						state_q     <= ST_PICK;
					end
				end
				// Nearest table entry inside the limits, one entry a cycle.
				ST_PICK: begin
					if (in_lim) begin
						if (raise_q ? (f_i >= tgt_q) : (f_i <= tgt_q)) begin
							if (!have_best_q || (raise_q ? f_i < best_q : f_i > best_q)) begin
								best_q      <= f_i;
								have_best_q <= 1'b1;
							end
						end else if (!have_alt_q || (raise_q ? f_i > alt_q : f_i < alt_q)) begin
							alt_q      <= f_i;
							have_alt_q <= 1'b1;
						end
					end
					if (idx_q == last_pt)
						state_q <= ST_CHOOSE;
					else
						idx_q <= idx_q + 3'd1;
				end
				ST_CHOOSE: begin
					freq_q  <= pick_khz;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					out_kind_q <= 1'b0;
					out_ok_q   <= 1'b0;
					peak_q     <= '0;
					out_khz_q  <= freq_q;
					out_chg_q  <= freq_q != cur_q;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/cpu_dvfs_load_governor.sv @@
// A load sample waits on the bit-serial divider that forms the load percent; a
// skipped sample or an ignored command leaves the block idle. A decide walks the
// table for the operating point; on a raise below the upper limit or a due lower it
// divides for the target, walks the table again for the nearest entry and chooses
// the result. A boost decide or a table write skips the walks and the divider. One
// item is in work at a time; the block takes no new item while a result waits.
module cpu_dvfs_load_governor (
	input  logic                          clk,
	input  logic                          arst_n,
	cdlg_in_if.sink                       in_ch,
	cdlg_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdlg_pkg::AddrBits-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cdlg_pkg::*;

	logic [FreqBits-1:0] limit_min_khz, limit_max_khz, fast_khz;
	logic [HoldBits-1:0] down_hold_samples, boost_hold_samples;
	logic [PctBits-1:0]  go_fast_load;
	logic [CntBits-1:0]  points_in_use;
	logic                hold_wr;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	cdlg_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.limit_min_khz, .limit_max_khz, .down_hold_samples, .go_fast_load,
		.fast_khz, .boost_hold_samples, .points_in_use, .hold_wr
	);

	cdlg_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	cdlg_seq u_seq (
		.clk, .arst_n, .in_ch, .out_ch,
		.limit_min_khz, .limit_max_khz, .down_hold_samples, .go_fast_load,
		.fast_khz, .boost_hold_samples, .points_in_use, .hold_wr,
		.div_req, .div_rsp
	);
endmodule

@@ hdl/cdlg_chk.sv @@
module cdlg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic        out_chg,
	input logic        out_ok,
	input logic [21:0] out_khz
);
	// A write acknowledge carries no frequency.
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> out_khz == '0 && !out_chg)
		else $error("write acknowledge with frequency");
	// A decision result never reports a write.
	a_dec_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> !out_ok)
		else $error("decision with write_ok");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_khz))
		else $error("result dropped");
	// No input beat is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(in_valid && in_ready))
		else $error("input taken while result waits");
endmodule

bind cpu_dvfs_load_governor cdlg_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.result_kind),
	.out_chg(out_ch.freq_changed), .out_ok(out_ch.write_ok), .out_khz(out_ch.target_khz)
);
